// ----- hdl/scpa_pkg.sv -----
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared widths, status codes and opcodes of the size-class pool allocator.
// ----------------------------------------------------------------------------
package scpa_pkg;

    localparam int REQ_W    = 16;
    localparam int CLASS_W  = 3;
    localparam int PSLOT_W  = 11;
    localparam int BYTES_W  = 15;
    localparam int STATUS_W = 3;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STAT_OK         = 3'd0;
    localparam status_t STAT_TOO_BIG    = 3'd1;
    localparam status_t STAT_EXHAUSTED  = 3'd2;
    localparam status_t STAT_BAD_HANDLE = 3'd3;
    localparam status_t STAT_NOT_IN_USE = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

// ----- hdl/scpa_store.sv -----
// ----------------------------------------------------------------------------
// scpa_store
// Free-list slot memory and in-use bit memory, both single write port with a
// registered read. Runs an initialisation sweep after reset that loads every
// class region with its slots in ascending order and clears the in-use bits.
// ----------------------------------------------------------------------------
module scpa_store #(
    parameter int TOTAL_SLOTS     = 7168,
    parameter int SLOTS_PER_CLASS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    output logic                             init_done,
    input  logic                             fifo_rd_en,
    input  logic [$clog2(TOTAL_SLOTS)-1:0]   fifo_rd_addr,
    output logic [$clog2(2*SLOTS_PER_CLASS)-1:0] fifo_rd_data,
    input  logic                             fifo_wr_en,
    input  logic [$clog2(TOTAL_SLOTS)-1:0]   fifo_wr_addr,
    input  logic [$clog2(2*SLOTS_PER_CLASS)-1:0] fifo_wr_data,
    input  logic                             use_rd_en,
    input  logic [$clog2(TOTAL_SLOTS)-1:0]   use_rd_addr,
    output logic                             use_rd_data,
    input  logic                             use_wr_en,
    input  logic [$clog2(TOTAL_SLOTS)-1:0]   use_wr_addr,
    input  logic                             use_wr_data
);

    localparam int ADDR_W = $clog2(TOTAL_SLOTS);
    localparam int SLOT_W = $clog2(2*SLOTS_PER_CLASS);

    logic [SLOT_W-1:0] fifo_mem [TOTAL_SLOTS];
    logic              use_mem  [TOTAL_SLOTS];

    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [SLOT_W-1:0] clr_slot_reg, clr_slot_next;
    logic              clr_first_reg, clr_first_next;
    logic              done_reg, done_next;

    logic              fifo_we, use_we, use_wd;
    logic [ADDR_W-1:0] fifo_wa, use_wa;
    logic [SLOT_W-1:0] fifo_wd;
    logic [SLOT_W-1:0] slot_last;

    assign init_done = done_reg;

    // class 0 region is twice as long as the others
    assign slot_last = clr_first_reg ? SLOT_W'(2*SLOTS_PER_CLASS - 1)
                                     : SLOT_W'(SLOTS_PER_CLASS - 1);

    always_comb
    begin
        clr_addr_next  = clr_addr_reg;
        clr_slot_next  = clr_slot_reg;
        clr_first_next = clr_first_reg;
        done_next      = done_reg;
        if (!done_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(TOTAL_SLOTS - 1))
                done_next = 1'b1;
            if (clr_slot_reg == slot_last)
            begin
                clr_slot_next  = '0;
                clr_first_next = 1'b0;
            end
            else
            begin
                clr_slot_next = clr_slot_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            clr_slot_reg  <= '0;
            clr_first_reg <= 1'b1;
            done_reg      <= 1'b0;
        end
        else
        begin
            clr_addr_reg  <= clr_addr_next;
            clr_slot_reg  <= clr_slot_next;
            clr_first_reg <= clr_first_next;
            done_reg      <= done_next;
        end
    end

    // write ports are owned by the sweep until it finishes
    always_comb
    begin
        if (!done_reg)
        begin
            fifo_we = 1'b1;
            fifo_wa = clr_addr_reg;
            fifo_wd = clr_slot_reg;
            use_we  = 1'b1;
            use_wa  = clr_addr_reg;
            use_wd  = 1'b0;
        end
        else
        begin
            fifo_we = fifo_wr_en;
            fifo_wa = fifo_wr_addr;
            fifo_wd = fifo_wr_data;
            use_we  = use_wr_en;
            use_wa  = use_wr_addr;
            use_wd  = use_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_we)
            fifo_mem[fifo_wa] <= fifo_wd;
    end

    always_ff @(posedge clk)
    begin
        if (fifo_rd_en)
            fifo_rd_data <= fifo_mem[fifo_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (use_we)
            use_mem[use_wa] <= use_wd;
    end

    always_ff @(posedge clk)
    begin
        if (use_rd_en)
            use_rd_data <= use_mem[use_rd_addr];
    end

endmodule

// ----- hdl/size_class_pool_allocator_core.sv -----
// A request transfer moves the core to EXEC, which registers the result once
// no earlier result is waiting. A new request is taken only back in IDLE,
// once the read then modify-and-write of the slot and in-use memories
// (one port each) is through. Reset: asynchronous, active low; afterwards
// an initialisation sweep over all (NUM_CLASSES + 1) * SLOTS_PER_CLASS slots
// (7168 by default) runs with in_ready low.
// ----------------------------------------------------------------------------
// size_class_pool_allocator_core
// Hands out (class, slot) buffer handles from per-class FIFO free lists and
// takes them back, checking handle range and in-use state.
// ----------------------------------------------------------------------------
module size_class_pool_allocator_core #(
    parameter int NUM_CLASSES     = 6,
    parameter int SLOTS_PER_CLASS = 1024,
    parameter int MIN_CLASS_BYTES = 512
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic [scpa_pkg::REQ_W-1:0]     request_bytes,
    input  logic [scpa_pkg::CLASS_W-1:0]   free_class,
    input  logic [scpa_pkg::PSLOT_W-1:0]   free_slot,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [scpa_pkg::STATUS_W-1:0]  status,
    output logic [scpa_pkg::CLASS_W-1:0]   size_class,
    output logic [scpa_pkg::PSLOT_W-1:0]   slot_index,
    output logic [scpa_pkg::BYTES_W-1:0]   block_bytes
);

    import scpa_pkg::*;

    localparam int TOTAL_SLOTS = (NUM_CLASSES + 1) * SLOTS_PER_CLASS;
    localparam int ADDR_W      = $clog2(TOTAL_SLOTS);
    localparam int SLOT_W      = $clog2(2*SLOTS_PER_CLASS);
    localparam int CNT_W       = $clog2(2*SLOTS_PER_CLASS + 1);
    localparam int CIDX_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    localparam logic [1:0] S_INIT = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    function automatic logic [31:0] class_bytes(input int c);
        return 32'(MIN_CLASS_BYTES) << c;
    endfunction

    function automatic logic [CNT_W-1:0] class_slots(input logic [CLASS_W-1:0] c);
        return (c == '0) ? CNT_W'(2*SLOTS_PER_CLASS) : CNT_W'(SLOTS_PER_CLASS);
    endfunction

    function automatic logic [ADDR_W-1:0] class_base(input logic [CLASS_W-1:0] c);
        return (c == '0) ? '0 : ADDR_W'((32'(c) + 32'd1) * 32'(SLOTS_PER_CLASS));
    endfunction

    logic [1:0]         state_reg, state_next;
    logic               op_reg, op_next;
    logic [CLASS_W-1:0] cls_reg, cls_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    status_t            pre_reg, pre_next;
    logic [ADDR_W-1:0]  base_reg, base_next;

    logic [SLOT_W-1:0]  head_reg  [NUM_CLASSES];
    logic [SLOT_W-1:0]  head_next [NUM_CLASSES];
    logic [SLOT_W-1:0]  tail_reg  [NUM_CLASSES];
    logic [SLOT_W-1:0]  tail_next [NUM_CLASSES];
    logic [CNT_W-1:0]   count_reg [NUM_CLASSES];
    logic [CNT_W-1:0]   count_next[NUM_CLASSES];

    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    logic [CLASS_W-1:0] size_class_reg, size_class_next;
    logic [PSLOT_W-1:0] slot_index_reg, slot_index_next;
    logic [BYTES_W-1:0] block_bytes_reg, block_bytes_next;

    // request decode
    logic [CLASS_W-1:0] alloc_cls, dec_cls;
    logic [CIDX_W-1:0]  alloc_idx, cidx;
    logic               too_big, bad_handle, exhausted, accept, exec_go;
    status_t            dec_stat;
    logic [ADDR_W-1:0]  dec_base;
    logic [CNT_W-1:0]   cls_n;

    // memory ports
    logic               init_done;
    logic               fifo_rd_en, fifo_wr_en, use_rd_en, use_wr_en, use_wr_data;
    logic [ADDR_W-1:0]  fifo_rd_addr, fifo_wr_addr, use_rd_addr, use_wr_addr;
    logic [SLOT_W-1:0]  fifo_rd_data, fifo_wr_data;
    logic               use_rd_data;

    scpa_store #(
        .TOTAL_SLOTS     (TOTAL_SLOTS),
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .init_done    (init_done),
        .fifo_rd_en   (fifo_rd_en),
        .fifo_rd_addr (fifo_rd_addr),
        .fifo_rd_data (fifo_rd_data),
        .fifo_wr_en   (fifo_wr_en),
        .fifo_wr_addr (fifo_wr_addr),
        .fifo_wr_data (fifo_wr_data),
        .use_rd_en    (use_rd_en),
        .use_rd_addr  (use_rd_addr),
        .use_rd_data  (use_rd_data),
        .use_wr_en    (use_wr_en),
        .use_wr_addr  (use_wr_addr),
        .use_wr_data  (use_wr_data)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign size_class  = size_class_reg;
    assign slot_index  = slot_index_reg;
    assign block_bytes = block_bytes_reg;

    // smallest class that fits; a zero size lands in class 0
    always_comb
    begin
        alloc_cls = CLASS_W'(NUM_CLASSES - 1);
        for (int k = NUM_CLASSES - 1; k >= 0; k--)
        begin
            if (32'(request_bytes) <= class_bytes(k))
                alloc_cls = CLASS_W'(k);
        end
    end

    assign too_big    = 32'(request_bytes) > class_bytes(NUM_CLASSES - 1);
    assign alloc_idx  = CIDX_W'(alloc_cls);
    assign exhausted  = (count_reg[alloc_idx] == '0);
    assign bad_handle = (32'(free_class) >= 32'(NUM_CLASSES))
                     || (32'(free_slot) >= 32'(class_slots(free_class)));
    assign dec_cls    = (opcode == OP_FREE) ? free_class : alloc_cls;
    assign dec_base   = class_base(dec_cls);

    always_comb
    begin
        if (opcode == OP_FREE)
            dec_stat = bad_handle ? STAT_BAD_HANDLE : STAT_OK;
        else if (too_big)
            dec_stat = STAT_TOO_BIG;
        else if (exhausted)
            dec_stat = STAT_EXHAUSTED;
        else
            dec_stat = STAT_OK;
    end

    // reads go out with the request transfer
    assign fifo_rd_en   = accept && (opcode == OP_ALLOC);
    assign fifo_rd_addr = class_base(alloc_cls) + ADDR_W'(head_reg[alloc_idx]);
    assign use_rd_en    = accept && (opcode == OP_FREE) && !bad_handle;
    assign use_rd_addr  = dec_base + ADDR_W'(SLOT_W'(free_slot));

    assign cidx    = CIDX_W'(cls_reg);
    assign cls_n   = class_slots(cls_reg);
    assign exec_go = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        cls_next         = cls_reg;
        slot_next        = slot_reg;
        pre_next         = pre_reg;
        base_next        = base_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        size_class_next  = size_class_reg;
        slot_index_next  = slot_index_reg;
        block_bytes_next = block_bytes_reg;
        fifo_wr_en       = 1'b0;
        fifo_wr_addr     = '0;
        fifo_wr_data     = '0;
        use_wr_en        = 1'b0;
        use_wr_addr      = '0;
        use_wr_data      = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                if (init_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                    op_next    = opcode;
                    cls_next   = dec_cls;
                    slot_next  = SLOT_W'(free_slot);
                    pre_next   = dec_stat;
                    base_next  = dec_base;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next       = S_IDLE;
                    out_valid_next   = 1'b1;
                    status_next      = pre_reg;
                    size_class_next  = cls_reg;
                    slot_index_next  = '0;
                    block_bytes_next = '0;
                    if (pre_reg == STAT_OK)
                    begin
                        if (op_reg == OP_ALLOC)
                        begin
                            slot_index_next  = PSLOT_W'(fifo_rd_data);
                            block_bytes_next = BYTES_W'(class_bytes(int'(cls_reg)));
                            head_next[cidx]  = (CNT_W'(head_reg[cidx]) + CNT_W'(1) == cls_n)
                                             ? '0 : head_reg[cidx] + SLOT_W'(1);
                            count_next[cidx] = count_reg[cidx] - CNT_W'(1);
                            use_wr_en        = 1'b1;
                            use_wr_addr      = base_reg + ADDR_W'(fifo_rd_data);
                            use_wr_data      = 1'b1;
                        end
                        else if (!use_rd_data)
                        begin
                            // double free: echo the handle, leave state alone
                            status_next     = STAT_NOT_IN_USE;
                            slot_index_next = PSLOT_W'(slot_reg);
                        end
                        else
                        begin
                            slot_index_next  = PSLOT_W'(slot_reg);
                            block_bytes_next = BYTES_W'(class_bytes(int'(cls_reg)));
                            use_wr_en        = 1'b1;
                            use_wr_addr      = base_reg + ADDR_W'(slot_reg);
                            use_wr_data      = 1'b0;
                            fifo_wr_en       = 1'b1;
                            fifo_wr_addr     = base_reg + ADDR_W'(tail_reg[cidx]);
                            fifo_wr_data     = slot_reg;
                            tail_next[cidx]  = (CNT_W'(tail_reg[cidx]) + CNT_W'(1) == cls_n)
                                             ? '0 : tail_reg[cidx] + SLOT_W'(1);
                            count_next[cidx] = count_reg[cidx] + CNT_W'(1);
                        end
                    end
                    else if (pre_reg == STAT_TOO_BIG || pre_reg == STAT_BAD_HANDLE)
                    begin
                        size_class_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c]  <= '0;
                tail_reg[c]  <= '0;
                count_reg[c] <= (c == 0) ? CNT_W'(2*SLOTS_PER_CLASS)
                                         : CNT_W'(SLOTS_PER_CLASS);
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        cls_reg         <= cls_next;
        slot_reg        <= slot_next;
        pre_reg         <= pre_next;
        base_reg        <= base_next;
        status_reg      <= status_next;
        size_class_reg  <= size_class_next;
        slot_index_reg  <= slot_index_next;
        block_bytes_reg <= block_bytes_next;
    end

endmodule
